>>> src/utc_pkg.sv
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, result codes and the CP437 upper-half lookup.
// ----------------------------------------------------------------------------
package utc_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] kind;
      logic       run_last;
   } rsp_type;

   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   typedef enum logic [1:0] {
      CLS_ASCII,
      CLS_LEAD,
      CLS_CONT,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       line_end;
      cls_type    cls;
      logic       drop;
      logic [2:0] lead_len;
      logic [4:0] lead_bits;
   } item_type;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   localparam logic [15:0] UPPER_HALF_TBL [128] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
   };

   // returns {found, cp437 byte}
   function automatic logic [8:0] map_cp437(input logic [20:0] cp);
      logic [8:0] res;
      res = 9'd0;
      if (cp >= 21'(CHAR_SPACE) && cp <= 21'(CHAR_TILDE)) begin
         res = {1'b1, cp[7:0]};
      end else if (cp == 21'(CHAR_TAB)) begin
         res = {1'b1, CHAR_SPACE};
      end else begin
         for (int i = 0; i < 128; i++) begin
            if (cp[20:16] == 5'd0 && cp[15:0] == UPPER_HALF_TBL[i]) begin
               res = {1'b1, 8'(i + 128)};
            end
         end
      end
      return res;
   endfunction

endpackage

>>> src/utc_fifo.sv
// ----------------------------------------------------------------------------
// utc_fifo
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module utc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/utc_front.sv
// ----------------------------------------------------------------------------
// utc_front
// Accepts request bytes, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
module utc_front import utc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   input  logic     q_pop,
   output item_type q_data,
   output logic     q_empty
);

   item_type item;
   logic [7:0] b;

   assign b = req_data.in_byte;

   always_comb begin
      item           = '0;
      item.byte_val  = b;
      item.line_end  = req_data.line_end;
      item.drop      = req_data.line_end && (b == CHAR_CR);
      item.cls       = CLS_OTHER;
      if (!b[7]) begin
         item.cls = CLS_ASCII;
      end else if (b[7:6] == 2'b10) begin
         item.cls = CLS_CONT;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         item.cls       = CLS_LEAD;
         item.lead_len  = 3'd2;
         item.lead_bits = b[4:0];
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         item.cls       = CLS_LEAD;
         item.lead_len  = 3'd3;
         item.lead_bits = {1'b0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         item.cls       = CLS_LEAD;
         item.lead_len  = 3'd4;
         item.lead_bits = {2'b0, b[2:0]};
      end
   end

   utc_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

endmodule

>>> src/utc_back.sv
// ----------------------------------------------------------------------------
// utc_back
// Decode sequencer: assembles code points, flushes failed sequences raw,
// maps to CP437 and writes results to the response queue.
// ----------------------------------------------------------------------------
module utc_back import utc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   output logic     q_pop,
   input  item_type q_data,
   input  logic     q_empty,
   output rsp_type  rsp_data,
   output logic     rsp_empty,
   input  logic     rsp_pop
);

   typedef enum logic [2:0] {
      S_IDLE, S_FEED, S_FLUSH, S_START, S_MAP, S_ENDCHK, S_ENDOUT, S_DONE
   } state_type;

   state_type   st_ff, st_in, after_ff, after_in;
   item_type    item_ff, item_in;
   logic [7:0]  pend_ff [4];
   logic [2:0]  cnt_ff, cnt_in, exp_ff, exp_in;
   logic [20:0] acc_ff, acc_in, cp_ff, cp_in, acc_new;
   logic        rej_ff, rej_in, nonempty_ff, nonempty_in;
   logic [1:0]  idx_ff, idx_in;
   logic        hold_valid_ff, hold_valid_in;
   rsp_type     hold_ff, hold_in;
   logic        pend_we;
   logic [1:0]  pend_wa;
   logic [7:0]  pend_wd;
   logic        emit_req, can_emit, oq_push, oq_full;
   rsp_type     emit_data, oq_data;
   logic        seq_bad;
   logic [8:0]  map_res;

   assign acc_new  = {acc_ff[14:0], item_ff.byte_val[5:0]};
   assign seq_bad  = (exp_ff == 3'd3 && acc_new < 21'h800) ||
                     (exp_ff == 3'd4 && acc_new < 21'h10000) ||
                     (acc_new >= 21'hD800 && acc_new <= 21'hDFFF) ||
                     (acc_new > 21'h10FFFF);
   assign map_res  = map_cp437(cp_ff);
   assign can_emit = !hold_valid_ff || !oq_full;

   always_comb begin
      st_in         = st_ff;
      after_in      = after_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      cp_in         = cp_ff;
      rej_in        = rej_ff;
      nonempty_in   = nonempty_ff;
      idx_in        = idx_ff;
      pend_we       = 1'b0;
      pend_wa       = cnt_ff[1:0];
      pend_wd       = item_ff.byte_val;
      emit_req      = 1'b0;
      emit_data     = '0;
      q_pop         = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_data;
               st_in   = S_FEED;
            end
         end
         S_FEED: begin
            if (rej_ff || item_ff.drop) begin
               st_in = S_ENDCHK;
            end else if (cnt_ff == 3'd0) begin
               st_in = S_START;
            end else if (item_ff.cls != CLS_CONT) begin
               idx_in   = 2'd0;
               after_in = S_START;
               st_in    = S_FLUSH;
            end else begin
               pend_we = 1'b1;
               cnt_in  = cnt_ff + 3'd1;
               acc_in  = acc_new;
               if (cnt_ff + 3'd1 < exp_ff) begin
                  st_in = S_ENDCHK;
               end else if (seq_bad) begin
                  idx_in   = 2'd0;
                  after_in = S_ENDCHK;
                  st_in    = S_FLUSH;
               end else begin
                  cnt_in = 3'd0;
                  cp_in  = acc_new;
                  st_in  = S_MAP;
               end
            end
         end
         S_FLUSH: begin
            emit_req  = 1'b1;
            emit_data = '{out_char: pend_ff[idx_ff], kind: KIND_CHAR, run_last: 1'b0};
            if (can_emit) begin
               nonempty_in = 1'b1;
               if ({1'b0, idx_ff} + 3'd1 == cnt_ff) begin
                  cnt_in = 3'd0;
                  st_in  = after_ff;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         S_START: begin
            case (item_ff.cls)
               CLS_ASCII: begin
                  cp_in = {13'd0, item_ff.byte_val};
                  st_in = S_MAP;
               end
               CLS_LEAD: begin
                  pend_we = 1'b1;
                  pend_wa = 2'd0;
                  cnt_in  = 3'd1;
                  exp_in  = item_ff.lead_len;
                  acc_in  = {16'd0, item_ff.lead_bits};
                  st_in   = S_ENDCHK;
               end
               default: begin
                  // stray continuation or invalid lead goes out raw
                  emit_req  = 1'b1;
                  emit_data = '{out_char: item_ff.byte_val, kind: KIND_CHAR,
                                run_last: 1'b0};
                  if (can_emit) begin
                     nonempty_in = 1'b1;
                     st_in       = S_ENDCHK;
                  end
               end
            endcase
         end
         S_MAP: begin
            if (!map_res[8]) begin
               rej_in = 1'b1;
               cnt_in = 3'd0;
               st_in  = S_ENDCHK;
            end else begin
               emit_req  = 1'b1;
               emit_data = '{out_char: map_res[7:0], kind: KIND_CHAR, run_last: 1'b0};
               if (can_emit) begin
                  nonempty_in = 1'b1;
                  st_in       = S_ENDCHK;
               end
            end
         end
         S_ENDCHK: begin
            if (item_ff.line_end && !rej_ff && cnt_ff != 3'd0) begin
               idx_in   = 2'd0;
               after_in = S_ENDOUT;
               st_in    = S_FLUSH;
            end else if (item_ff.line_end) begin
               st_in = S_ENDOUT;
            end else begin
               st_in = S_DONE;
            end
         end
         S_ENDOUT: begin
            emit_req  = 1'b1;
            emit_data = '{out_char: 8'd0,
                          kind: rej_ff ? KIND_REJECT :
                                (nonempty_ff ? KIND_ACCEPT : KIND_EMPTY),
                          run_last: 1'b0};
            if (can_emit) begin
               rej_in      = 1'b0;
               nonempty_in = 1'b0;
               cnt_in      = 3'd0;
               exp_in      = 3'd0;
               acc_in      = 21'd0;
               st_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!hold_valid_ff || !oq_full) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // the newest result waits in a hold register until the next one tells
   // whether it closes the run
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      oq_push       = 1'b0;
      oq_data       = hold_ff;
      if (emit_req && can_emit) begin
         oq_push       = hold_valid_ff;
         hold_valid_in = 1'b1;
         hold_in       = emit_data;
      end else if (st_ff == S_DONE && hold_valid_ff && !oq_full) begin
         oq_push           = 1'b1;
         oq_data.run_last  = 1'b1;
         hold_valid_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         after_ff      <= S_IDLE;
         cnt_ff        <= 3'd0;
         exp_ff        <= 3'd0;
         acc_ff        <= 21'd0;
         rej_ff        <= 1'b0;
         nonempty_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         after_ff      <= after_in;
         cnt_ff        <= cnt_in;
         exp_ff        <= exp_in;
         acc_ff        <= acc_in;
         rej_ff        <= rej_in;
         nonempty_ff   <= nonempty_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cp_ff   <= cp_in;
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      if (pend_we) begin
         pend_ff[pend_wa] <= pend_wd;
      end
   end

   utc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (oq_push),
      .push_data (oq_data),
      .full      (oq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

>>> src/utf8_to_cp437_line_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_cp437_line_transcoder_top
// Strict UTF-8 line decoder producing CP437 characters and a line verdict.
// ----------------------------------------------------------------------------
// Bytes are pushed into a request queue and handled one at a time by a decode
// sequencer; results come out of a response queue, each byte's last result
// flagged by run_last and every line closed by one accepted, rejected or
// empty verdict. The sequencer takes an extra step for each byte flushed raw
// from a failed sequence and another for the line verdict; back pressure on
// the response side stalls it.
module utf8_to_cp437_line_transcoder_top import utc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   item_type q_data;
   logic     q_pop, q_empty;

   utc_front #(.QUEUE_DEPTH (QUEUE_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_pop    (q_pop),
      .q_data   (q_data),
      .q_empty  (q_empty)
   );

   utc_back #(.QUEUE_DEPTH (QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

>>> src/utc_checker.sv
// ----------------------------------------------------------------------------
// utc_checker
// Port-level checks on the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module utc_checker import utc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // verdicts carry no character and always close their run
   a_verdict_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind != KIND_CHAR) |->
         (rsp_data.out_char == 8'd0 && rsp_data.run_last))
      else $error("verdict with character or open run");

   // the response queue comes out of reset empty and the request queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting response vanished");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting response changed");

endmodule

bind utf8_to_cp437_line_transcoder_top utc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

>>> sim/utc_line_checker.sv
// ----------------------------------------------------------------------------
// utc_line_checker
// Watches both queues of the transcoder, predicts the CP437 results of every
// accepted request and compares each popped result with the oldest one due.
// ----------------------------------------------------------------------------
module utc_line_checker import utc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      results_due
);

   rsp_type    due_q[$];
   rsp_type    step_q[$];
   logic [7:0] seq_bytes [4];
   int         seq_count;
   int         seq_len;
   logic [20:0] code_acc;
   logic       line_bad;
   logic       line_sent;

   assign results_due = due_q.size();

   function automatic int cp437_of(logic [20:0] cp);
      if (cp >= 21'h20 && cp <= 21'h7E) return int'(cp);
      if (cp == 21'(CHAR_TAB)) return int'(CHAR_SPACE);
      for (int i = 0; i < 128; i++) begin
         if (cp == 21'(UPPER_HALF_TBL[i])) return i + 128;
      end
      return -1;
   endfunction

   task automatic put_char(logic [7:0] ch, logic [1:0] k);
      rsp_type r;
      if (step_q.size() < 6) begin
         r.out_char = ch;
         r.kind = k;
         r.run_last = 1'b0;
         step_q = {step_q, r};
      end
   endtask

   task automatic give_code(logic [20:0] cp);
      int m;
      m = cp437_of(cp);
      if (m < 0) begin
         line_bad = 1'b1;
         seq_count = 0;
      end else begin
         put_char(8'(m), KIND_CHAR);
         line_sent = 1'b1;
      end
   endtask

   task automatic flush_seq();
      for (int i = 0; i < seq_count && i < 4; i++) begin
         put_char(seq_bytes[i], KIND_CHAR);
         line_sent = 1'b1;
      end
      seq_count = 0;
   endtask

   task automatic open_seq(logic [7:0] b);
      if (b < 8'h80) begin
         give_code(21'(b));
      end else if (b >= 8'hC2 && b <= 8'hF4) begin
         seq_bytes[0] = b;
         seq_count = 1;
         if (b <= 8'hDF) begin
            seq_len = 2;
            code_acc = 21'(b[4:0]);
         end else if (b <= 8'hEF) begin
            seq_len = 3;
            code_acc = 21'(b[3:0]);
         end else begin
            seq_len = 4;
            code_acc = 21'(b[2:0]);
         end
      end else begin
         put_char(b, KIND_CHAR);
         line_sent = 1'b1;
      end
   endtask

   task automatic take_byte(logic [7:0] b);
      if (seq_count == 0) begin
         open_seq(b);
      end else if (b[7:6] != 2'b10) begin
         flush_seq();
         open_seq(b);
      end else begin
         seq_bytes[seq_count & 3] = b;
         seq_count++;
         code_acc = {code_acc[14:0], b[5:0]};
         if (seq_count >= seq_len) begin
            if ((seq_len == 3 && code_acc < 21'h800) ||
                (seq_len == 4 && code_acc < 21'h10000) ||
                (code_acc >= 21'hD800 && code_acc <= 21'hDFFF) ||
                code_acc > 21'h10FFFF) begin
               flush_seq();
            end else begin
               seq_count = 0;
               give_code(code_acc);
            end
         end
      end
   endtask

   task automatic predict_request(req_type q);
      logic [1:0] verdict;
      step_q.delete();
      if (!line_bad && !(q.line_end && q.in_byte == CHAR_CR)) take_byte(q.in_byte);
      if (q.line_end && !line_bad && seq_count != 0) flush_seq();
      if (q.line_end) begin
         verdict = line_bad ? KIND_REJECT : (line_sent ? KIND_ACCEPT : KIND_EMPTY);
         put_char(8'h00, verdict);
         line_bad = 1'b0;
         line_sent = 1'b0;
         seq_count = 0;
         seq_len = 0;
         code_acc = '0;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
      due_q = {due_q, step_q};
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         seq_count = 0;
         seq_len = 0;
         code_acc = '0;
         line_bad = 1'b0;
         line_sent = 1'b0;
         due_q.delete();
         fail_count = 0;
      end else begin
         if (req_push && !req_full) predict_request(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (due_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result %h", $time, rsp_data);
            end else begin
               want = due_q.pop_front();
               if (rsp_data.out_char !== want.out_char || rsp_data.kind !== want.kind ||
                   rsp_data.run_last !== want.run_last) begin
                  fail_count++;
                  $display("%0t: expected char %h kind %0d last %0d, got char %h kind %0d last %0d",
                           $time, want.out_char, want.kind, want.run_last,
                           rsp_data.out_char, rsp_data.kind, rsp_data.run_last);
               end
            end
         end
      end
   end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text lines into the UTF-8 to CP437 transcoder: directed corner cases,
// then random lines under several idle and stall mixes; a checker compares.
// ----------------------------------------------------------------------------
module testbench;
   import utc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      results_due;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;
   int      sent = 0;
   logic [7:0] line_q[$];

   always #5 clock = ~clock;

   utf8_to_cp437_line_transcoder_top i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   utc_line_checker i_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .fail_count(fail_count), .results_due(results_due)
   );

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("utf8_to_cp437_line_transcoder_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic [7:0] b, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data.in_byte = b;
      req_data.line_end = last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // the whole buffered line, last byte flagged
   task automatic send_line();
      if (line_q.size() == 0) line_q = {line_q, CHAR_CR};
      foreach (line_q[i]) send_request(line_q[i], i == line_q.size() - 1);
      line_q.delete();
   endtask

   task automatic add_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
         line_q = {line_q, cp[7:0]};
      end else if (cp < 21'h800) begin
         line_q = {line_q, {3'b110, cp[10:6]}};
         line_q = {line_q, {2'b10, cp[5:0]}};
      end else if (cp < 21'h10000) begin
         line_q = {line_q, {4'b1110, cp[15:12]}};
         line_q = {line_q, {2'b10, cp[11:6]}};
         line_q = {line_q, {2'b10, cp[5:0]}};
      end else begin
         line_q = {line_q, {5'b11110, cp[20:18]}};
         line_q = {line_q, {2'b10, cp[17:12]}};
         line_q = {line_q, {2'b10, cp[11:6]}};
         line_q = {line_q, {2'b10, cp[5:0]}};
      end
   endtask

   task automatic random_line();
      int n;
      n = $urandom_range(6);
      repeat (n) begin
         case ($urandom_range(11))
            0, 1, 2, 3: line_q = {line_q, 8'($urandom_range(8'h7E, 8'h20))};
            4: line_q = {line_q, CHAR_TAB};
            5, 6, 7: add_utf8(21'(UPPER_HALF_TBL[$urandom_range(127)]));
            8: add_utf8(21'($urandom_range(21'h10FFFF)));
            9: line_q = {line_q, 8'($urandom)};
            10: begin
               // lead byte with up to two random continuations: truncated, overlong or complete
               line_q = {line_q, 8'($urandom_range(8'hF4, 8'hC2))};
               repeat ($urandom_range(2)) line_q = {line_q, {2'b10, 6'($urandom)}};
            end
            default: line_q = {line_q, 8'($urandom_range(8'h1F))};
         endcase
      end
      if ($urandom_range(1)) line_q = {line_q, CHAR_CR};
      send_line();
   endtask

   task automatic random_phase(int idle, int stall, int count);
      int goal;
      idle_pct = idle;
      stall_pct = stall;
      goal = sent + count;
      while (sent < goal) random_line();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      line_q = '{8'h41, 8'h7E, CHAR_TAB, 8'h20, CHAR_CR};       send_line();
      line_q = '{CHAR_CR};                                       send_line();
      line_q = '{8'hC3, 8'hA9, 8'hE2, 8'h96, 8'h91};             send_line();
      line_q = '{8'hE0, 8'h80, 8'h80};                           send_line();
      line_q = '{8'hED, 8'hA0, 8'h80, 8'hC3};                    send_line();
      line_q = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'h80};      send_line();
      line_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41, 8'h00};      send_line();
      line_q = '{CHAR_CR, 8'h41};                                send_line();
      line_q = '{8'h00};                                         send_line();

      random_phase(0, 0, 45);
      random_phase(85, 0, 40);
      random_phase(0, 85, 40);
      random_phase(35, 35, 40);
      req_push = 1'b0;

      while (results_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("utf8_to_cp437_line_transcoder_top: match");
      end else begin
         $display("utf8_to_cp437_line_transcoder_top: mismatch");
      end
      $finish;
   end

endmodule
